>>> rtl/cce_pkg.sv
// shared types, message bytes and zoom table for the camera command encoder
package cce_pkg;

    localparam int NUM_SETTINGS_DEF = 9;
    localparam int QUEUE_DEPTH = 2;

    // fixed message bytes
    localparam logic [7:0] BYTE_ADDR  = 8'h81;
    localparam logic [7:0] BYTE_CAT   = 8'h01;
    localparam logic [7:0] BYTE_GRP   = 8'h04;
    localparam logic [7:0] BYTE_ZOOM  = 8'h47;
    localparam logic [7:0] BYTE_END   = 8'hFF;

    // setting command bytes
    localparam logic [7:0] CMD_BRIGHT = 8'h0D;
    localparam logic [7:0] CMD_IRCUT  = 8'h01;
    localparam logic [7:0] CMD_STAB   = 8'h34;
    localparam logic [7:0] CMD_SMOOTH = 8'h53;

    // setting ids that send a message
    localparam logic [3:0] SET_BRIGHT = 4'd1;
    localparam logic [3:0] SET_IRCUT  = 4'd4;
    localparam logic [3:0] SET_STAB   = 4'd5;
    localparam logic [3:0] SET_SMOOTH = 4'd6;

    // request kinds
    localparam logic REQ_SETTING = 1'b0;
    localparam logic REQ_ZOOM    = 1'b1;

    // byte positions
    localparam logic [3:0] IDX_CMD       = 4'd3;
    localparam logic [3:0] IDX_ARG       = 4'd4;
    localparam logic [3:0] IDX_SET_LAST  = 4'd5;
    localparam logic [3:0] IDX_ZOOM_LAST = 4'd8;

    // one queued message, bytes 0..2 and the end byte are implied
    typedef struct packed {
        logic       is_zoom;
        logic [7:0] cmd;
        logic [7:0] arg;
        logic [3:0] nib_q;
        logic [3:0] nib_r;
        logic [3:0] nib_s;
    } msg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // direct zoom nibbles p q r s; out-of-table positions use position 1
    function automatic logic [15:0] zoom_nibbles(input logic [7:0] pos);
        logic [15:0] r;
        begin
            case (pos)
                8'd2:    r = 16'h166F;
                8'd3:    r = 16'h1FF0;
                8'd4:    r = 16'h257D;
                8'd5:    r = 16'h2940;
                8'd6:    r = 16'h2C02;
                8'd7:    r = 16'h2E2B;
                8'd8:    r = 16'h2FEE;
                8'd9:    r = 16'h316A;
                8'd10:   r = 16'h32B2;
                default: r = 16'h0000;
            endcase
            return r;
        end
    endfunction

endpackage

>>> rtl/cce_front.sv
// front end: classifies requests, keeps zoom and setting state, builds messages
module cce_front
    import cce_pkg::*;
#(
    parameter int NUM_SETTINGS = NUM_SETTINGS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       req_type,
    input  logic [3:0] setting_id,
    input  logic [7:0] value,
    output logic       push,
    output msg_t       push_msg
);

    localparam int IDX_W = $clog2(NUM_SETTINGS);

    logic [7:0]       last_zoom_reg;
    logic [7:0]       last_zoom_next;
    logic [7:0]       store_reg [NUM_SETTINGS];
    logic [IDX_W-1:0] idx;
    logic             in_range;
    logic [7:0]       stored;
    logic             zoom_change;
    logic             set_change;
    logic             set_has_msg;
    logic [15:0]      nibs;

    assign idx      = setting_id[IDX_W-1:0];
    assign in_range = ({1'b0, setting_id} < 5'(NUM_SETTINGS));
    assign stored   = in_range ? store_reg[idx] : 8'h00;

    assign zoom_change = accept && (req_type == REQ_ZOOM) && (value != last_zoom_reg);
    assign set_change  = accept && (req_type == REQ_SETTING) && in_range && (value != stored);
    assign nibs        = zoom_nibbles(value);

    always_comb
    begin
        last_zoom_next = last_zoom_reg;
        if (zoom_change)
        begin
            last_zoom_next = value;
        end
    end

    always_comb
    begin
        push_msg.is_zoom = (req_type == REQ_ZOOM);
        push_msg.cmd     = BYTE_ZOOM;
        push_msg.arg     = {4'h0, nibs[15:12]};
        push_msg.nib_q   = nibs[11:8];
        push_msg.nib_r   = nibs[7:4];
        push_msg.nib_s   = nibs[3:0];
        set_has_msg      = 1'b1;
        if (req_type == REQ_SETTING)
        begin
            case (setting_id)
                SET_BRIGHT:
                begin
                    push_msg.cmd = CMD_BRIGHT;
                    push_msg.arg = (value == 8'd1) ? 8'h02 :
                                   (value == 8'd2) ? 8'h03 : 8'h00;
                end
                SET_IRCUT:
                begin
                    push_msg.cmd = CMD_IRCUT;
                    push_msg.arg = (value == 8'd1) ? 8'h02 : 8'h03;
                end
                SET_STAB:
                begin
                    push_msg.cmd = CMD_STAB;
                    push_msg.arg = (value == 8'd1) ? 8'h03 : 8'h02;
                end
                SET_SMOOTH:
                begin
                    push_msg.cmd = CMD_SMOOTH;
                    push_msg.arg = value;
                end
                default:
                begin
                    set_has_msg = 1'b0;
                end
            endcase
        end
    end

    assign push = zoom_change || (set_change && set_has_msg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_zoom_reg <= 8'd1;
            for (int i = 0; i < NUM_SETTINGS; i++)
            begin
                store_reg[i] <= 8'h00;
            end
        end
        else
        begin
            last_zoom_reg <= last_zoom_next;
            if (set_change)
            begin
                store_reg[idx] <= value;
            end
        end
    end

endmodule

>>> rtl/cce_queue.sv
// short message queue between front end and serializer
module cce_queue
    import cce_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  msg_t      push_msg,
    input  logic      pop,
    output msg_t      head,
    output q_status_t status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    msg_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_msg;
        end
    end

endmodule

>>> rtl/cce_back.sv
// back end: walks the head message out one byte per out_valid/out_ready handshake
module cce_back
    import cce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  msg_t       head,
    input  q_status_t  status,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] tx_byte,
    output logic       last
);

    logic [3:0] idx_reg;
    logic [3:0] idx_next;
    logic       fire;

    assign out_valid = !status.empty;
    assign fire      = out_valid && out_ready;
    assign last      = head.is_zoom ? (idx_reg == IDX_ZOOM_LAST) : (idx_reg == IDX_SET_LAST);
    assign pop       = fire && last;

    always_comb
    begin
        case (idx_reg)
            4'd0:    tx_byte = BYTE_ADDR;
            4'd1:    tx_byte = BYTE_CAT;
            4'd2:    tx_byte = BYTE_GRP;
            IDX_CMD: tx_byte = head.cmd;
            IDX_ARG: tx_byte = head.arg;
            4'd5:    tx_byte = head.is_zoom ? {4'h0, head.nib_q} : BYTE_END;
            4'd6:    tx_byte = {4'h0, head.nib_r};
            4'd7:    tx_byte = {4'h0, head.nib_s};
            default: tx_byte = BYTE_END;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (fire)
        begin
            idx_next = last ? 4'd0 : idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 4'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

>>> rtl/camera_command_encoder.sv
// camera command encoder top level: front end, message queue and byte serializer
//
//   channel  dir  handshake              fields
//   in       in   in_valid / in_ready    req_type, setting_id, value
//   out      out  out_valid / out_ready  tx_byte, last
//
// a request is classified in the cycle it is accepted; a message is queued
// a zoom message is 9 bytes and a setting message 6, one byte per cycle while out_ready is high
// the serializer sets the rate; the front takes requests while the 2-deep queue has room
// requests with no message are taken whenever the queue is not full
// reset: last zoom 1, all settings 0, queue empty
module camera_command_encoder
    import cce_pkg::*;
#(
    parameter int NUM_SETTINGS = NUM_SETTINGS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       req_type,
    input  logic [3:0] setting_id,
    input  logic [7:0] value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] tx_byte,
    output logic       last
);

    logic      push;
    msg_t      push_msg;
    logic      pop;
    msg_t      head;
    q_status_t status;

    assign in_ready = !status.full;

    cce_front #(
        .NUM_SETTINGS(NUM_SETTINGS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_valid && in_ready),
        .req_type  (req_type),
        .setting_id(setting_id),
        .value     (value),
        .push      (push),
        .push_msg  (push_msg)
    );

    cce_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_msg(push_msg),
        .pop     (pop),
        .head    (head),
        .status  (status)
    );

    cce_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .status   (status),
        .pop      (pop),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .tx_byte  (tx_byte),
        .last     (last)
    );

    // the final byte of any message is the terminator
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (tx_byte == BYTE_END))
        else $error("message ends without terminator");

    // after a message completes, the next byte shown opens a new message
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> (!out_valid || tx_byte == BYTE_ADDR))
        else $error("message does not start with address byte");

    // queue never reports full and empty together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(status.full && status.empty))
        else $error("queue status inconsistent");

    // nothing is queued into a full queue unless an entry is popped in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && status.full) |-> pop)
        else $error("push into full queue");

endmodule
